FILE: design/hill_cipher_mod37_block_top_defines.svh
// assertion macros shared by the hill cipher block
`ifndef HILL_CIPHER_MOD37_BLOCK_TOP_DEFINES_SVH
`define HILL_CIPHER_MOD37_BLOCK_TOP_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define HCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define HCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hcm_pkg.sv
`timescale 1ns / 1ps

package hcm_pkg;

    // largest block size and key order
    localparam int MAX_BLOCK = 16;

    localparam int MODULUS      = 37;
    localparam int SYM_W        = 6;
    localparam int SPACE_SYMBOL = 36;
    localparam int BS_W         = 5;

    localparam int SYM_AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int KEY_DEPTH = MAX_BLOCK * MAX_BLOCK;
    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    // unreduced dot product: key entries up to 63, symbols up to 36
    localparam int KEY_MAX = (1 << SYM_W) - 1;
    localparam int PROD_W  = 2 * SYM_W;
    localparam int ACC_W   = $clog2(MAX_BLOCK * KEY_MAX * (MODULUS - 1) + 1);

    // reciprocal of the modulus, exact for any accumulator value
    localparam int RECIP_SH = ACC_W + 6;
    localparam int RECIP    = ((1 << RECIP_SH) + MODULUS - 1) / MODULUS;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int MUL_W    = ACC_W + RECIP_W;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_CHAR = 1'b1;

    localparam logic [7:0] CH_A     = "A";
    localparam logic [7:0] CH_Z     = "Z";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_SPACE = " ";

    typedef struct packed {
        logic       req_type;
        logic [3:0] key_row;
        logic [3:0] key_col;
        logic [5:0] key_value;
        logic [7:0] char_code;
        logic       message_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] cipher_char;
        logic       block_last;
    } t_out_beat;

    typedef struct packed {
        logic clr;  // drop the running sum and any residue
        logic en;   // add one key * symbol product
        logic red;  // start reducing the finished sum
    } t_mac_ctl;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] residue;
    } t_mac_sts;

    function automatic logic [SYM_W-1:0] to_symbol(input logic [7:0] c);
        logic [SYM_W-1:0] s;
        if (c inside {[CH_A:CH_Z]}) begin
            s = SYM_W'(c - CH_A);
        end else if (c inside {[CH_0:CH_9]}) begin
            s = SYM_W'(c - CH_0) + SYM_W'(26);
        end else if (c == CH_SPACE) begin
            s = SYM_W'(SPACE_SYMBOL);
        end else begin
            s = '0;
        end
        return s;
    endfunction

    function automatic logic [7:0] to_char(input logic [SYM_W-1:0] s);
        logic [7:0] c;
        if (s < SYM_W'(26)) begin
            c = CH_A + 8'(s);
        end else if (s < SYM_W'(36)) begin
            c = CH_0 + 8'(s - SYM_W'(26));
        end else begin
            c = CH_SPACE;
        end
        return c;
    endfunction

    function automatic logic [KEY_AW-1:0] key_addr(input int unsigned row,
                                                   input int unsigned col);
        return KEY_AW'(row * MAX_BLOCK + col);
    endfunction

endpackage

FILE: design/hcm_ram.sv
`timescale 1ns / 1ps

module hcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: design/hcm_mac.sv
`timescale 1ns / 1ps

module hcm_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hcm_pkg::t_mac_ctl            i_ctl,
    input  logic [hcm_pkg::SYM_W-1:0]    i_key,
    input  logic [hcm_pkg::SYM_W-1:0]    i_sym,
    output hcm_pkg::t_mac_sts            o_sts
);
    import hcm_pkg::*;

    logic [ACC_W-1:0]          r_acc;
    logic [MUL_W-1:0]          r_prod;
    logic [SYM_W-1:0]          r_res;
    logic                      r_v1;
    logic                      r_done;
    logic [PROD_W-1:0]         w_mul;
    logic [MUL_W-RECIP_SH-1:0] w_quot;

    assign w_mul  = PROD_W'(i_key) * PROD_W'(i_sym);
    assign w_quot = r_prod[MUL_W-1:RECIP_SH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctl.clr) begin
            r_acc  <= '0;
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_ctl.en) begin
                r_acc <= r_acc + ACC_W'(w_mul);
            end
            r_v1   <= i_ctl.red;
            r_done <= r_done | r_v1;
        end
    end

    // sum mod 37 in two steps: quotient by reciprocal, then subtract
    always_ff @(posedge i_clk) begin
        if (i_ctl.red) begin
            r_prod <= MUL_W'(r_acc) * MUL_W'(RECIP);
        end
        if (r_v1) begin
            r_res <= SYM_W'(r_acc - ACC_W'(32'(w_quot) * MODULUS));
        end
    end

    assign o_sts.valid   = r_done;
    assign o_sts.residue = r_res;

endmodule

FILE: design/hill_cipher_mod37_block_top.sv
`timescale 1ns / 1ps
// channel   | signals                              | direction
// ----------+--------------------------------------+-----------
// input     | i_in_valid, o_in_ready, i_in_beat    | in
// output    | o_out_valid, i_out_ready, o_out_beat | out
// config    | i_cfg_we, i_cfg_wdata                | in
//
// a padded block writes its spaces into the symbol memory in the pad state
// each cipher character is then computed from n reads of the key and
// symbol memories, one multiply-accumulate a cycle, a reduction and a load
// synchronous reset: block size 1, no symbols held; memories are not cleared
// the output register holds a beat while the next row is computed; input is
// taken again as soon as the last beat of a block is loaded
`include "hill_cipher_mod37_block_top_defines.svh"

module hill_cipher_mod37_block_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  hcm_pkg::t_in_beat           i_in_beat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output hcm_pkg::t_out_beat          o_out_beat,
    input  logic                        i_cfg_we,
    input  logic [hcm_pkg::BS_W-1:0]    i_cfg_wdata
);
    import hcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_MAC,
        S_RED,
        S_LOAD
    } t_state;

    t_state           r_state;
    logic [BS_W-1:0]  r_block_size;
    logic [CNT_W-1:0] r_fill;
    logic [SYM_AW-1:0] r_row;
    logic [CNT_W-1:0] r_col;
    logic             r_issue_v;
    logic             r_issue_last;
    logic             r_out_valid;
    t_out_beat        r_out_beat;

    logic [CNT_W-1:0] w_n;
    logic             w_in_acc;
    logic             w_char;
    logic [CNT_W-1:0] w_fill_eff;
    logic [CNT_W-1:0] w_fill_nxt;
    logic             w_key_we;
    logic             w_sym_we;
    logic [SYM_AW-1:0] w_sym_waddr;
    logic [SYM_W-1:0] w_sym_wdata;
    logic             w_issue;
    logic             w_load;
    logic             w_last_row;
    logic [SYM_W-1:0] w_key_rdata;
    logic [SYM_W-1:0] w_sym_rdata;
    t_mac_ctl         w_ctl;
    t_mac_sts         w_sts;

    // effective block size: zero acts as one, large values clamp
    always_comb begin
        if (r_block_size == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_block_size) > MAX_BLOCK) begin
            w_n = CNT_W'(MAX_BLOCK);
        end else begin
            w_n = CNT_W'(r_block_size);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_char     = w_in_acc && (i_in_beat.req_type == REQ_CHAR);
    assign w_fill_eff = (r_fill >= w_n) ? '0 : r_fill;
    assign w_fill_nxt = w_fill_eff + CNT_W'(1);

    // key writes outside the matrix are dropped
    assign w_key_we = w_in_acc && (i_in_beat.req_type == REQ_KEY)
                   && (32'(i_in_beat.key_row) < MAX_BLOCK)
                   && (32'(i_in_beat.key_col) < MAX_BLOCK);

    // symbol memory: mapped character on accept, spaces while padding
    assign w_sym_we    = w_char || (r_state == S_PAD);
    assign w_sym_waddr = (r_state == S_PAD) ? r_fill[SYM_AW-1:0] : w_fill_eff[SYM_AW-1:0];
    assign w_sym_wdata = (r_state == S_PAD) ? SYM_W'(SPACE_SYMBOL)
                                            : to_symbol(i_in_beat.char_code);

    // one read of row r_row, column r_col per cycle
    assign w_issue    = (r_state == S_MAC) && (r_col < w_n);
    assign w_last_row = (32'(r_row) + 1 == 32'(w_n));
    assign w_load     = (r_state == S_LOAD) && w_sts.valid
                     && (!r_out_valid || i_out_ready);

    assign w_ctl.clr = (r_state == S_IDLE) || (r_state == S_PAD) || w_load;
    assign w_ctl.en  = r_issue_v;
    assign w_ctl.red = (r_state == S_RED);

    hcm_ram #(
        .WIDTH (SYM_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (key_addr(32'(i_in_beat.key_row), 32'(i_in_beat.key_col))),
        .i_wdata (i_in_beat.key_value),
        .i_raddr (key_addr(32'(r_row), 32'(r_col[SYM_AW-1:0]))),
        .o_rdata (w_key_rdata)
    );

    // writes land in an earlier cycle than any read of the same block,
    // so the state machine alone keeps read and write apart
    hcm_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_BLOCK)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (w_sym_we),
        .i_waddr (w_sym_waddr),
        .i_wdata (w_sym_wdata),
        .i_raddr (r_col[SYM_AW-1:0]),
        .o_rdata (w_sym_rdata)
    );

    hcm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_key   (w_key_rdata),
        .i_sym   (w_sym_rdata),
        .o_sts   (w_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_block_size <= BS_W'(1);
            r_fill       <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_issue_v    <= 1'b0;
            r_issue_last <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // output register: a new beat may replace one being taken
            if (w_load) begin
                r_out_valid            <= 1'b1;
                r_out_beat.cipher_char <= to_char(w_sts.residue);
                r_out_beat.block_last  <= w_last_row;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // read data is registered, so it shows up in the cycle after the address
            r_issue_v    <= w_issue;
            r_issue_last <= ((r_col + CNT_W'(1)) == w_n);
            if (w_issue) begin
                r_col <= r_col + CNT_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_block_size <= i_cfg_wdata;
                        r_fill       <= '0;
                    end
                    if (w_char) begin
                        if (w_fill_nxt >= w_n) begin
                            r_state <= S_MAC;
                            r_row   <= '0;
                            r_col   <= '0;
                        end else if (i_in_beat.message_end) begin
                            r_fill  <= w_fill_nxt;
                            r_state <= S_PAD;
                        end else begin
                            r_fill <= w_fill_nxt;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + CNT_W'(1);
                    if ((r_fill + CNT_W'(1)) >= w_n) begin
                        r_state <= S_MAC;
                        r_row   <= '0;
                        r_col   <= '0;
                    end
                end
                S_MAC: begin
                    // last product is added at this edge
                    if (r_issue_v && r_issue_last) begin
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_load) begin
                        if (w_last_row) begin
                            r_state <= S_IDLE;
                            r_fill  <= '0;
                        end else begin
                            r_row   <= r_row + SYM_AW'(1);
                            r_col   <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // a partial block never reaches the block size while waiting for input
    `HCM_ASSERT_NOW(a_fill_below_n, i_clk, i_rst_n, (r_state == S_IDLE), (r_fill < w_n), "fill count reached block size while idle")
    // finishing the last row returns to accepting input
    `HCM_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, (w_load && w_last_row), (r_state == S_IDLE), "last beat of block did not end emission")
    // memory read data is only summed while a row is being computed
    `HCM_ASSERT_NOW(a_issue_in_mac, i_clk, i_rst_n, r_issue_v, (r_state == S_MAC), "read data valid outside row computation")
    // a finished residue only waits in the load state
    `HCM_ASSERT_NOW(a_residue_in_load, i_clk, i_rst_n, w_sts.valid, (r_state == S_LOAD), "residue ready outside load state")

endmodule
